[rtl/ert_pkg.sv]
// ----------------------------------------------------------------------------
// Echo request tracker package
// Shared types, command and result codes for the echo request tracker.
// ----------------------------------------------------------------------------
package ert_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [1:0] CMD_REQUEST = 2'd0;
    localparam logic [1:0] CMD_PACKET  = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    localparam logic [2:0] KIND_OK        = 3'd0;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_DUP       = 3'd3;
    localparam logic [2:0] KIND_UNMATCHED = 3'd4;
    localparam logic [2:0] KIND_BADTYPE   = 3'd5;

    localparam logic [7:0] TYPE_REPLY   = 8'h00;
    localparam logic [7:0] TYPE_REQUEST = 8'h08;

    localparam logic [7:0] LIMIT_RESET = 8'd5;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] ident;
        logic [15:0] seq;
    } key_t;

    typedef struct packed {
        key_t       key;
        logic [7:0] age;
    } entry_t;

    typedef struct packed {
        logic [2:0] kind;
        key_t       key;
        logic       last;
    } result_t;

endpackage

[rtl/ert_table.sv]
// ----------------------------------------------------------------------------
// Echo request tracker entry table
// Simple dual-port memory of keys and ages with a registered read.
// ----------------------------------------------------------------------------
module ert_table #(
    parameter int TABLE_DEPTH = ert_pkg::DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic [IDX_W-1:0]      rd_idx,
    output ert_pkg::entry_t       rd_entry,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_idx,
    input  ert_pkg::entry_t       wr_entry
);
    import ert_pkg::*;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    assign rd_entry = rd_entry_reg;

endmodule

[rtl/ert_out_reg.sv]
// ----------------------------------------------------------------------------
// Echo request tracker output register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module ert_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ert_pkg::result_t  push_res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [63:0]       m_tdata,
    output logic [2:0]        m_tuser,
    output logic              m_tlast
);
    import ert_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= push_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.key.seq, res_reg.key.ident, res_reg.key.addr};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.last;

endmodule

[rtl/ert_ctrl.sv]
// ----------------------------------------------------------------------------
// Echo request tracker sequencer
// Scans one table entry per cycle unless a tick waits on output, with a shared
// key compare and age update, then allocates, frees or reports per command.
// ----------------------------------------------------------------------------
module ert_ctrl #(
    parameter int TABLE_DEPTH = ert_pkg::DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_cmd,
    input  ert_pkg::key_t         s_key,
    input  logic [7:0]            s_type,
    input  logic [7:0]            limit,
    output logic [IDX_W-1:0]      rd_idx,
    input  ert_pkg::entry_t       rd_entry,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_idx,
    output ert_pkg::entry_t       wr_entry,
    output logic                  push,
    output ert_pkg::result_t      push_res,
    input  logic                  out_free
);
    import ert_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [1:0] OP_REQ     = 2'd0;
    localparam logic [1:0] OP_REPLY   = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_BADTYPE = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [1:0]             state_reg, state_next;
    logic [1:0]             op_reg, op_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    key_t                   key_reg, key_next;
    logic                   match_found_reg, match_found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    key_t                   pend_reg, pend_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;

    logic       advance;
    logic       at_last;
    logic       result_due;
    logic [8:0] age_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign at_last  = (ptr_reg == LAST_IDX);
    assign age_inc  = {1'b0, rd_entry.age} + 9'd1;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        ptr_next         = ptr_reg;
        key_next         = key_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        pend_valid_next  = pend_valid_reg;
        pend_next        = pend_reg;
        valid_next       = valid_reg;
        advance          = 1'b1;
        result_due       = 1'b0;
        wr_en            = 1'b0;
        wr_idx           = ptr_reg;
        wr_entry.key     = rd_entry.key;
        wr_entry.age     = age_inc[7:0];
        push             = 1'b0;
        push_res.kind    = KIND_OK;
        push_res.key     = key_reg;
        push_res.last    = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next         = s_key;
                    ptr_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    pend_valid_next  = 1'b0;
                    unique case (s_cmd)
                        CMD_REQUEST:
                        begin
                            op_next    = OP_REQ;
                            state_next = ST_SCAN;
                        end
                        CMD_PACKET:
                        begin
                            if (s_type == TYPE_REPLY)
                            begin
                                op_next    = OP_REPLY;
                                state_next = ST_SCAN;
                            end
                            else if (s_type != TYPE_REQUEST)
                            begin
                                op_next    = OP_BADTYPE;
                                state_next = ST_FINISH;
                            end
                        end
                        CMD_TICK:
                        begin
                            op_next    = OP_TICK;
                            state_next = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (op_reg == OP_TICK)
                begin
                    if (valid_reg[ptr_reg])
                    begin
                        if (age_inc > {1'b0, limit})
                        begin
                            if (pend_valid_reg && !out_free)
                            begin
                                advance = 1'b0;
                            end
                            else
                            begin
                                push              = pend_valid_reg;
                                push_res.kind     = KIND_TIMEOUT;
                                push_res.key      = pend_reg;
                                push_res.last     = 1'b0;
                                pend_next         = rd_entry.key;
                                pend_valid_next   = 1'b1;
                                valid_next[ptr_reg] = 1'b0;
                            end
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (valid_reg[ptr_reg] && rd_entry.key == key_reg && !match_found_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = ptr_reg;
                    end
                    if (!valid_reg[ptr_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = ptr_reg;
                    end
                end
                if (advance)
                begin
                    if (at_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
            end
            ST_FINISH:
            begin
                unique case (op_reg)
                    OP_REQ:     result_due = match_found_reg || !free_found_reg;
                    OP_REPLY:   result_due = 1'b1;
                    OP_TICK:    result_due = pend_valid_reg;
                    OP_BADTYPE: result_due = 1'b1;
                endcase
                if (out_free || !result_due)
                begin
                    state_next = ST_IDLE;
                    push       = result_due;
                    unique case (op_reg)
                        OP_REQ:
                        begin
                            if (match_found_reg)
                            begin
                                push_res.kind = KIND_DUP;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en        = 1'b1;
                                wr_idx       = free_idx_reg;
                                wr_entry.key = key_reg;
                                wr_entry.age = '0;
                                valid_next[free_idx_reg] = 1'b1;
                            end
                            else
                            begin
                                push_res.kind = KIND_FULL;
                            end
                        end
                        OP_REPLY:
                        begin
                            if (match_found_reg)
                            begin
                                push_res.kind = KIND_OK;
                                valid_next[match_idx_reg] = 1'b0;
                            end
                            else
                            begin
                                push_res.kind = KIND_UNMATCHED;
                            end
                        end
                        OP_TICK:
                        begin
                            push_res.kind   = KIND_TIMEOUT;
                            push_res.key    = pend_reg;
                            pend_valid_next = 1'b0;
                        end
                        OP_BADTYPE:
                        begin
                            push_res.kind = KIND_BADTYPE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (state_reg == ST_SCAN)
        begin
            rd_idx = (advance && !at_last) ? ptr_reg + 1'b1 : ptr_reg;
        end
        else
        begin
            rd_idx = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            op_reg          <= OP_REQ;
            ptr_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            pend_valid_reg  <= pend_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            op_reg          <= op_next;
            ptr_reg         <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        match_idx_reg <= match_idx_next;
        free_idx_reg  <= free_idx_next;
        pend_reg      <= pend_next;
    end

endmodule

[rtl/echo_request_tracker.sv]
// ----------------------------------------------------------------------------
// Echo request tracker
// Table of outstanding ICMP echo requests with duplicate, reply and timeout
// reporting.
// ----------------------------------------------------------------------------
// A request, an echo reply or a timer tick reads and compares one table entry
// per cycle through the single read port of the entry memory, and a final
// state allocates, frees or reports. A clear command or a received echo
// request completes without leaving idle, and any other received type goes
// straight to the final state. A command that reports waits in its final
// state while the output register is still occupied, and a tick that expires
// several entries also waits during its scan. Results leave through a
// one-deep output register, and the last result of each input transaction
// that reports carries tlast. Timeout limit writes are always accepted and
// take effect from the next cycle, so they belong between input transactions.
module echo_request_tracker #(
    parameter int TABLE_DEPTH = ert_pkg::DEFAULT_TABLE_DEPTH,
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // dest_addr, echo_ident, echo_seq, pkt_type
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // res_addr, res_ident, res_seq
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import ert_pkg::*;

    logic [7:0]       limit_reg;
    logic [7:0]       limit_next;
    key_t             s_key;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic             push;
    result_t          push_res;
    logic             out_free;

    assign cfg_ready   = 1'b1;
    assign limit_next  = cfg_valid ? cfg_data : limit_reg;
    assign s_key.addr  = s_tdata[31:0];
    assign s_key.ident = s_tdata[47:32];
    assign s_key.seq   = s_tdata[63:48];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    ert_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk      (clk),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry)
    );

    ert_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .s_key    (s_key),
        .s_type   (s_tdata[71:64]),
        .limit    (limit_reg),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_entry (wr_entry),
        .push     (push),
        .push_res (push_res),
        .out_free (out_free)
    );

    ert_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_CLEAR) |=> s_tready)
        else $error("clear transaction did not return to ready");

    a_request_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_REQUEST) |=> !s_tready)
        else $error("request transaction did not start a table scan");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= KIND_BADTYPE))
        else $error("result transaction carries an undefined kind");

endmodule
